// File: hdl/jbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbt_pkg
// Shared types, codes and character helpers for the JSON byte tokenizer.
// ----------------------------------------------------------------------------
package jbt_pkg;

  localparam int unsigned LineWidthDef   = 16;
  localparam int unsigned ColumnWidthDef = 16;
  localparam int unsigned ResFifoDepth   = 4;

  typedef enum logic [3:0] {
    TOK_EOF      = 4'd0,
    TOK_LBRACE   = 4'd1,
    TOK_RBRACE   = 4'd2,
    TOK_LBRACKET = 4'd3,
    TOK_RBRACKET = 4'd4,
    TOK_COLON    = 4'd5,
    TOK_COMMA    = 4'd6,
    TOK_STRING   = 4'd7,
    TOK_NUMBER   = 4'd8,
    TOK_TRUE     = 4'd9,
    TOK_FALSE    = 4'd10,
    TOK_NULL     = 4'd11,
    TOK_COMMENT  = 4'd12,
    TOK_INVALID  = 4'd13
  } tok_e;

  // Keyword prefix tracker codes
  localparam logic [3:0] KwNone  = 4'd0;
  localparam logic [3:0] KwT     = 4'd1;
  localparam logic [3:0] KwTrue  = 4'd4;
  localparam logic [3:0] KwF     = 4'd5;
  localparam logic [3:0] KwFalse = 4'd9;
  localparam logic [3:0] KwN     = 4'd10;
  localparam logic [3:0] KwNull  = 4'd13;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChUnder     = 8'h5F;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChMinus     = 8'h2D;
  localparam logic [7:0] ChPlus      = 8'h2B;
  localparam logic [7:0] ChDot       = 8'h2E;

  // One result slot produced by the lexer for an accepted item
  typedef struct packed {
    logic       valid;
    logic       is_token;
    tok_e       ttype;
    logic [7:0] chr;
  } res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  // Next expected letter for each keyword prefix; zero where none
  function automatic logic [7:0] kw_next(input logic [3:0] kw);
    logic [7:0] r;
    unique case (kw)
      4'd1:    r = 8'h72; // r
      4'd2:    r = 8'h75; // u
      4'd3:    r = 8'h65; // e
      4'd5:    r = 8'h61; // a
      4'd6:    r = 8'h6C; // l
      4'd7:    r = 8'h73; // s
      4'd8:    r = 8'h65; // e
      4'd10:   r = 8'h75; // u
      4'd11:   r = 8'h6C; // l
      4'd12:   r = 8'h6C; // l
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic tok_e ident_type(input logic [3:0] kw);
    tok_e t;
    if (kw == KwTrue) begin
      t = TOK_TRUE;
    end else if (kw == KwFalse) begin
      t = TOK_FALSE;
    end else if (kw == KwNull) begin
      t = TOK_NULL;
    end else begin
      t = TOK_STRING;
    end
    return t;
  endfunction

endpackage

// File: hdl/jbt_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbt_lexer
// Scan state and position counters; decodes one item per cycle, advancing
// only while take_i is high, into up to two result slots.
// ----------------------------------------------------------------------------
module jbt_lexer import jbt_pkg::*; #(
  parameter int unsigned LINE_WIDTH   = LineWidthDef,
  parameter int unsigned COLUMN_WIDTH = ColumnWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    take_i,
  input  logic                    kind_i,
  input  logic [7:0]              data_i,
  output res_t                    res0_o,
  output res_t                    res1_o,
  output logic [LINE_WIDTH-1:0]   line_o,
  output logic [COLUMN_WIDTH-1:0] col_o
);

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_STR   = 3'd1,
    M_ESC   = 3'd2,
    M_NUM   = 3'd3,
    M_IDENT = 3'd4,
    M_SLASH = 3'd5,
    M_CLEAD = 3'd6,
    M_CBODY = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    POS_HOLD,
    POS_COL,
    POS_LINE
  } pos_e;

  mode_e                   mode_q, mode_d;
  logic [3:0]              kw_q, kw_d;
  logic [LINE_WIDTH-1:0]   line_q, line_d;
  logic [COLUMN_WIDTH-1:0] col_q, col_d;

  pos_e       pos_act;
  logic       idle_run;
  logic       tok_past;
  res_t       pre_res, main_res;
  logic [7:0] c;
  logic [7:0] want;

  assign c    = data_i;
  assign want = kw_next(kw_q);

  always_comb begin
    mode_d   = mode_q;
    kw_d     = kw_q;
    pos_act  = POS_HOLD;
    idle_run = 1'b0;
    tok_past = 1'b0;
    pre_res  = '0;
    main_res = '0;

    if (kind_i) begin
      // End item: close the open token, then eof
      unique case (mode_q)
        M_STR, M_ESC: pre_res = '{valid: 1'b1, is_token: 1'b1, ttype: TOK_STRING, chr: 8'h00};
        M_NUM:        pre_res = '{valid: 1'b1, is_token: 1'b1, ttype: TOK_NUMBER, chr: 8'h00};
        M_IDENT:      pre_res = '{valid: 1'b1, is_token: 1'b1, ttype: ident_type(kw_q),
                                  chr: 8'h00};
        M_SLASH, M_CLEAD, M_CBODY:
                      pre_res = '{valid: 1'b1, is_token: 1'b1, ttype: TOK_COMMENT, chr: 8'h00};
        default:      pre_res = '0;
      endcase
      main_res = '{valid: 1'b1, is_token: 1'b1, ttype: TOK_EOF, chr: 8'h00};
      mode_d   = M_IDLE;
      kw_d     = KwNone;
    end else begin
      unique case (mode_q)
        M_STR: begin
          if (c == ChQuote) begin
            // closing quote: the token reports the position past the quote
            pos_act  = POS_COL;
            tok_past = 1'b1;
            main_res = '{valid: 1'b1, is_token: 1'b1, ttype: TOK_STRING, chr: 8'h00};
            mode_d   = M_IDLE;
          end else begin
            main_res = '{valid: 1'b1, is_token: 1'b0, ttype: TOK_EOF, chr: c};
            pos_act  = (c == ChNewline) ? POS_LINE : POS_COL;
            if (c == ChBackslash) begin
              mode_d = M_ESC;
            end
          end
        end
        M_ESC: begin
          main_res = '{valid: 1'b1, is_token: 1'b0, ttype: TOK_EOF, chr: c};
          pos_act  = (c == ChNewline) ? POS_LINE : POS_COL;
          mode_d   = M_STR;
        end
        M_NUM: begin
          if (is_digit(c) || c == ChDot || c == ChMinus || c == 8'h65 || c == 8'h45 ||
              c == ChPlus || c == ChUnder) begin
            main_res = '{valid: 1'b1, is_token: 1'b0, ttype: TOK_EOF, chr: c};
            pos_act  = POS_COL;
          end else begin
            pre_res  = '{valid: 1'b1, is_token: 1'b1, ttype: TOK_NUMBER, chr: 8'h00};
            idle_run = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == ChUnder) begin
            kw_d     = (want != 8'h00 && want == c) ? kw_q + 4'd1 : KwNone;
            main_res = '{valid: 1'b1, is_token: 1'b0, ttype: TOK_EOF, chr: c};
            pos_act  = POS_COL;
          end else begin
            pre_res  = '{valid: 1'b1, is_token: 1'b1, ttype: ident_type(kw_q), chr: 8'h00};
            kw_d     = KwNone;
            idle_run = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == ChSlash) begin
            pos_act = POS_COL;
            mode_d  = M_CLEAD;
          end else begin
            pre_res  = '{valid: 1'b1, is_token: 1'b1, ttype: TOK_INVALID, chr: 8'h00};
            idle_run = 1'b1;
          end
        end
        M_CLEAD, M_CBODY: begin
          if (c == ChNewline) begin
            pre_res  = '{valid: 1'b1, is_token: 1'b1, ttype: TOK_COMMENT, chr: 8'h00};
            idle_run = 1'b1;
          end else if (mode_q == M_CLEAD && (c == ChSpace || c == ChTab || c == ChCr)) begin
            // drop leading blanks of the comment body
            pos_act = POS_COL;
          end else begin
            main_res = '{valid: 1'b1, is_token: 1'b0, ttype: TOK_EOF, chr: c};
            pos_act  = POS_COL;
            mode_d   = M_CBODY;
          end
        end
        default: idle_run = 1'b1;
      endcase

      if (idle_run) begin
        mode_d = M_IDLE;
        priority if (c == ChSpace || c == ChTab || c == ChCr) begin
          pos_act = POS_COL;
        end else if (c == ChNewline) begin
          pos_act = POS_LINE;
        end else if (c == ChSlash) begin
          pos_act = POS_COL;
          mode_d  = M_SLASH;
        end else if (c == 8'h7B) begin
          main_res = '{valid: 1'b1, is_token: 1'b1, ttype: TOK_LBRACE, chr: 8'h00};
          pos_act  = POS_COL;
        end else if (c == 8'h7D) begin
          main_res = '{valid: 1'b1, is_token: 1'b1, ttype: TOK_RBRACE, chr: 8'h00};
          pos_act  = POS_COL;
        end else if (c == 8'h5B) begin
          main_res = '{valid: 1'b1, is_token: 1'b1, ttype: TOK_LBRACKET, chr: 8'h00};
          pos_act  = POS_COL;
        end else if (c == 8'h5D) begin
          main_res = '{valid: 1'b1, is_token: 1'b1, ttype: TOK_RBRACKET, chr: 8'h00};
          pos_act  = POS_COL;
        end else if (c == 8'h3A) begin
          main_res = '{valid: 1'b1, is_token: 1'b1, ttype: TOK_COLON, chr: 8'h00};
          pos_act  = POS_COL;
        end else if (c == 8'h2C) begin
          main_res = '{valid: 1'b1, is_token: 1'b1, ttype: TOK_COMMA, chr: 8'h00};
          pos_act  = POS_COL;
        end else if (c == ChQuote) begin
          pos_act = POS_COL;
          mode_d  = M_STR;
        end else if (is_digit(c) || c == ChMinus) begin
          main_res = '{valid: 1'b1, is_token: 1'b0, ttype: TOK_EOF, chr: c};
          pos_act  = POS_COL;
          mode_d   = M_NUM;
        end else if (is_alpha(c)) begin
          main_res = '{valid: 1'b1, is_token: 1'b0, ttype: TOK_EOF, chr: c};
          kw_d     = (c == 8'h74) ? KwT : (c == 8'h66) ? KwF : (c == 8'h6E) ? KwN : KwNone;
          pos_act  = POS_COL;
          mode_d   = M_IDENT;
        end else begin
          main_res = '{valid: 1'b1, is_token: 1'b1, ttype: TOK_INVALID, chr: 8'h00};
          pos_act  = POS_COL;
        end
      end
    end
  end

  // Saturating position update
  always_comb begin
    line_d = line_q;
    col_d  = col_q;
    unique case (pos_act)
      POS_COL: begin
        if (col_q != '1) begin
          col_d = col_q + COLUMN_WIDTH'(1);
        end
      end
      POS_LINE: begin
        if (line_q != '1) begin
          line_d = line_q + LINE_WIDTH'(1);
        end
        col_d = COLUMN_WIDTH'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      kw_q   <= KwNone;
      line_q <= LINE_WIDTH'(1);
      col_q  <= COLUMN_WIDTH'(1);
    end else if (take_i) begin
      mode_q <= mode_d;
      kw_q   <= kw_d;
      line_q <= line_d;
      col_q  <= col_d;
    end
  end

  // Pack: a token cut by this byte goes first
  assign res0_o = pre_res.valid ? pre_res : main_res;
  assign res1_o = pre_res.valid ? main_res : res_t'('0);
  assign line_o = line_q;
  assign col_o  = tok_past ? col_d : col_q;

endmodule

// File: hdl/jbt_res_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbt_res_fifo
// Small result queue: up to two writes per cycle, one read per cycle.
// ----------------------------------------------------------------------------
module jbt_res_fifo import jbt_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = ResFifoDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push0_i,
  input  logic [WIDTH-1:0] data0_i,
  input  logic             push1_i,
  input  logic [WIDTH-1:0] data1_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  output logic             room2_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d, wr_nxt;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign do_pop = pop_i && (cnt_q != '0);
  assign wr_nxt = ptr_inc(wr_q);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push0_i && push1_i) begin
      wr_d  = ptr_inc(wr_nxt);
      cnt_d = cnt_d + CntW'(2);
    end else if (push0_i) begin
      wr_d  = wr_nxt;
      cnt_d = cnt_d + CntW'(1);
    end
    if (do_pop) begin
      rd_d  = ptr_inc(rd_q);
      cnt_d = cnt_d - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_q] <= data0_i;
    end
    if (push0_i && push1_i) begin
      mem_q[wr_nxt] <= data1_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign room2_o = (cnt_q <= CntW'(DEPTH - 2));

endmodule

// File: hdl/jsonc_byte_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsonc_byte_tokenizer
// JSON lexer with line comments: streams literal bytes and token records.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  tdata                        tuser         tlast
//  s_axis    in   [7:0] data_byte              kind          -
//  m_axis    out  token_type, content_byte,    result_kind   last
//                 line_number, column_number
//
// One item per cycle while the queue has room: the lexer decodes the
// accepted byte in the cycle it is accepted and writes its zero, one or two
// results into a four-entry result queue, whose head drives the output.
// Input is taken whenever the queue holds two entries or fewer, so a steady
// stream of one result per byte runs at one item per cycle while the output
// is ready. The input stalls once more than two entries wait: under a run
// of items that each yield two results, bound by the one-result-per-cycle
// output, and under a stalled output, which holds its head item steady.
// Reset returns the lexer to idle at line 1, column 1 and empties the queue.
// ----------------------------------------------------------------------------
module jsonc_byte_tokenizer import jbt_pkg::*; #(
  parameter int unsigned LINE_WIDTH   = LineWidthDef,
  parameter int unsigned COLUMN_WIDTH = ColumnWidthDef,
  localparam int unsigned OutBits     = 12 + LINE_WIDTH + COLUMN_WIDTH,
  localparam int unsigned OutTdataW   = ((OutBits + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [7:0]           s_axis_tdata_i,  // [7:0] data_byte
  input  logic                 s_axis_tuser_i,  // kind: 0 data byte, 1 end of input
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // from bit 0: token_type(4), content_byte(8), line_number, column_number, zero pad
  output logic [OutTdataW-1:0] m_axis_tdata_o,
  output logic                 m_axis_tuser_o,  // result_kind: 0 content, 1 token
  output logic                 m_axis_tlast_o   // last result of the input item
);

  localparam int unsigned EntW = OutBits + 2;

  logic                    take;
  logic                    room2;
  res_t                    res0, res1;
  logic [LINE_WIDTH-1:0]   tok_line;
  logic [COLUMN_WIDTH-1:0] tok_col;
  logic [EntW-1:0]         ent0, ent1, ent_out;

  // Accept only while the queue can take the worst case of two results
  assign s_axis_tready_o = room2;
  assign take            = s_axis_tvalid_i && room2;

  jbt_lexer #(
    .LINE_WIDTH   (LINE_WIDTH),
    .COLUMN_WIDTH (COLUMN_WIDTH)
  ) u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .kind_i (s_axis_tuser_i),
    .data_i (s_axis_tdata_i),
    .res0_o (res0),
    .res1_o (res1),
    .line_o (tok_line),
    .col_o  (tok_col)
  );

  // Build a queue entry: {last, kind, column, line, byte, type}.
  // Content results carry zero type and position; tokens carry zero byte.
  function automatic logic [EntW-1:0] pack_res(
    input res_t                    r,
    input logic                    is_last,
    input logic [LINE_WIDTH-1:0]   ln,
    input logic [COLUMN_WIDTH-1:0] cl
  );
    logic [LINE_WIDTH-1:0]   l;
    logic [COLUMN_WIDTH-1:0] k;
    logic [3:0]              t;
    logic [7:0]              b;
    l = r.is_token ? ln : '0;
    k = r.is_token ? cl : '0;
    t = r.is_token ? r.ttype : 4'd0;
    b = r.is_token ? 8'h00 : r.chr;
    return {is_last, r.is_token, k, l, b, t};
  endfunction

  assign ent0 = pack_res(res0, !res1.valid, tok_line, tok_col);
  assign ent1 = pack_res(res1, 1'b1, tok_line, tok_col);

  jbt_res_fifo #(
    .WIDTH (EntW),
    .DEPTH (ResFifoDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (take && res0.valid),
    .data0_i (ent0),
    .push1_i (take && res1.valid),
    .data1_i (ent1),
    .pop_i   (m_axis_tready_i),
    .valid_o (m_axis_tvalid_o),
    .data_o  (ent_out),
    .room2_o (room2)
  );

  assign m_axis_tdata_o = OutTdataW'(ent_out[OutBits-1:0]);
  assign m_axis_tuser_o = ent_out[OutBits];
  assign m_axis_tlast_o = ent_out[OutBits+1];

endmodule
